[rtl/stl_pkg.sv]
package stl_pkg;

	localparam int LINE_BITS_DEF   = 20;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF = 16;

	// Scan modes.
	localparam logic [3:0] M_IDLE     = 4'd0;
	localparam logic [3:0] M_SLASH    = 4'd1;
	localparam logic [3:0] M_LINECMT  = 4'd2;
	localparam logic [3:0] M_BLOCKCMT = 4'd3;
	localparam logic [3:0] M_IDENT    = 4'd4;
	localparam logic [3:0] M_ZERO     = 4'd5;
	localparam logic [3:0] M_INT      = 4'd6;
	localparam logic [3:0] M_HEX      = 4'd7;
	localparam logic [3:0] M_FRAC     = 4'd8;
	localparam logic [3:0] M_EXPSTART = 4'd9;
	localparam logic [3:0] M_EXPDIG   = 4'd10;
	localparam logic [3:0] M_STRING   = 4'd11;
	localparam logic [3:0] M_OPER     = 4'd12;

	// Token kinds.
	localparam logic [5:0] K_EOF   = 6'd0;
	localparam logic [5:0] K_ID    = 6'd1;
	localparam logic [5:0] K_INT   = 6'd2;
	localparam logic [5:0] K_FLOAT = 6'd3;
	localparam logic [5:0] K_STR   = 6'd4;
	localparam logic [5:0] K_CMT   = 6'd5;
	localparam logic [5:0] K_KW0   = 6'd26;
	localparam logic [5:0] K_CHAR  = 6'd41;
	localparam logic [5:0] K_ERR   = 6'd42;
	localparam logic [5:0] K_NONE  = 6'd0;

	typedef logic [71:0] word_t;

	// One emitted token, before position fields are attached.
	typedef struct packed {
		logic       valid;
		logic       use_cur; // position from current counters (eof, string error, char token in slot 1)
		logic [5:0] kind;
		logic [7:0] ch;
	} tok_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == "$";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d;
	endfunction

	function automatic logic is_opstart(input logic [7:0] b);
		return b == "=" || b == "!" || b == "<" || b == ">" || b == "+" || b == "-" ||
			b == "&" || b == "|" || b == "^";
	endfunction

	// Two-character operator kind, zero if none.
	function automatic logic [5:0] op2(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] s;
		s = {a, b};
		case (s)
			"==": return 6'd6;
			"!=": return 6'd8;
			"<=": return 6'd10;
			"<<": return 6'd11;
			">=": return 6'd13;
			">>": return 6'd14;
			"+=": return 6'd17;
			"-=": return 6'd18;
			"++": return 6'd19;
			"--": return 6'd20;
			"&=": return 6'd21;
			"&&": return 6'd22;
			"|=": return 6'd23;
			"||": return 6'd24;
			"^=": return 6'd25;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] op3(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic [23:0] s;
		s = {a, b, c};
		case (s)
			"===": return 6'd7;
			"!==": return 6'd9;
			"<<=": return 6'd12;
			">>>": return 6'd15;
			">>=": return 6'd16;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic is_prefix3(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] s;
		s = {a, b};
		return s == "==" || s == "!=" || s == "<<" || s == ">>";
	endfunction

	// Keyword lookup; the word is stored first character in the low byte.
	function automatic logic [5:0] kw_kind(input word_t w);
		word_t k [15];
		logic [5:0] r;
		k[0]  = word_t'({"fi"});
		k[1]  = word_t'({"esle"});
		k[2]  = word_t'({"od"});
		k[3]  = word_t'({"elihw"});
		k[4]  = word_t'({"rof"});
		k[5]  = word_t'({"kaerb"});
		k[6]  = word_t'({"eunitnoc"});
		k[7]  = word_t'({"noitcnuf"});
		k[8]  = word_t'({"nruter"});
		k[9]  = word_t'({"rav"});
		k[10] = word_t'({"eurt"});
		k[11] = word_t'({"eslaf"});
		k[12] = word_t'({"llun"});
		k[13] = word_t'({"denifednu"});
		k[14] = word_t'({"wen"});
		r = K_ID;
		for (int i = 0; i < 15; i++) begin
			if (w == k[i]) r = K_KW0 + 6'(i);
		end
		return r;
	endfunction

endpackage

[rtl/stl_core.sv]
module stl_core
	import stl_pkg::*;
#(
	parameter int LINE_BITS   = LINE_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             b,
	input  logic                   drop,
	output tok_t                   t0,
	output tok_t                   t1,
	output logic [LINE_BITS-1:0]   tok_line,
	output logic [COLUMN_BITS-1:0] tok_col,
	output logic [LENGTH_BITS-1:0] tok_len,
	output logic [LINE_BITS-1:0]   cur_line,
	output logic [COLUMN_BITS-1:0] cur_col
);

	localparam logic [LINE_BITS-1:0]   LMAX = '1;
	localparam logic [COLUMN_BITS-1:0] CMAX = '1;
	localparam logic [LENGTH_BITS-1:0] NMAX = '1;

	logic [3:0]             mode_q, mode_d;
	word_t                  word_q, word_d;
	logic                   long_q, long_d;
	logic [7:0]             pre0_q, pre0_d, pre1_q, pre1_d;
	logic                   pcnt2_q, pcnt2_d;
	logic [7:0]             quote_q, quote_d;
	logic                   esc_q, esc_d, star_q, star_d, halt_q, halt_d;
	logic [LINE_BITS-1:0]   line_q, tline_q, tline_d;
	logic [COLUMN_BITS-1:0] col_q, tcol_q, tcol_d;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic [LENGTH_BITS-1:0] len0;
	logic                   restart;
	logic [3:0]             m;
	logic [5:0]             k;

	assign cnt_inc = (cnt_q == NMAX) ? cnt_q : cnt_q + 1'b1;

	// Next-state logic for one byte: finish the running token, then maybe start one.
	always_comb begin
		mode_d = mode_q; word_d = word_q; long_d = long_q; pre0_d = pre0_q;
		pre1_d = pre1_q; pcnt2_d = pcnt2_q; quote_d = quote_q; esc_d = esc_q;
		star_d = star_q; halt_d = halt_q; tline_d = tline_q; tcol_d = tcol_q;
		cnt_d = cnt_q; t0 = '0; t1 = '0; restart = 1'b0; len0 = cnt_q; k = K_NONE;
		m = (mode_q == M_ZERO && !(b == "x" || b == "X")) ? M_INT : mode_q;
		case (m)
			M_SLASH: begin
				if (b == "/") begin
					mode_d = M_LINECMT; cnt_d = cnt_inc;
				end else if (b == "*") begin
					mode_d = M_BLOCKCMT; star_d = 1'b0; cnt_d = cnt_inc;
				end else begin
					t0 = '{1'b1, 1'b0, K_CHAR, "/"}; restart = 1'b1;
				end
			end
			M_LINECMT: begin
				if (b == 8'h00 || b == 8'h0a) begin
					t0 = '{!drop, 1'b0, K_CMT, 8'h00}; restart = 1'b1;
				end else cnt_d = cnt_inc;
			end
			M_BLOCKCMT: begin
				if (b == 8'h00) begin
					t0 = '{1'b1, 1'b0, K_ERR, 8'h00}; halt_d = 1'b1; mode_d = M_IDLE;
				end else begin
					cnt_d = cnt_inc;
					if (star_q && b == "/") begin
						t0 = '{!drop, 1'b0, K_CMT, 8'h00}; mode_d = M_IDLE; len0 = cnt_inc;
					end else star_d = (b == "*");
				end
			end
			M_IDENT: begin
				if (is_alpha(b) || is_digit(b)) begin
					if (!long_q && cnt_q < LENGTH_BITS'(9)) begin
						for (int i = 1; i < 9; i++)
							if (cnt_q == LENGTH_BITS'(i)) word_d[i*8 +: 8] = b;
					end else long_d = 1'b1;
					cnt_d = cnt_inc;
				end else begin
					t0 = '{1'b1, 1'b0, long_q ? K_ID : kw_kind(word_q), 8'h00};
					restart = 1'b1;
				end
			end
			M_ZERO: begin
				mode_d = M_HEX; cnt_d = cnt_inc;
			end
			M_INT: begin
				mode_d = M_INT;
				if (is_digit(b)) cnt_d = cnt_inc;
				else if (b == ".") begin
					mode_d = M_FRAC; cnt_d = cnt_inc;
				end else if (b == "e" || b == "E") begin
					mode_d = M_EXPSTART; cnt_d = cnt_inc;
				end else begin
					t0 = '{1'b1, 1'b0, K_INT, 8'h00}; restart = 1'b1;
				end
			end
			M_HEX: begin
				if (is_hex(b)) cnt_d = cnt_inc;
				else begin
					t0 = '{1'b1, 1'b0, K_INT, 8'h00}; restart = 1'b1;
				end
			end
			M_FRAC: begin
				if (is_digit(b)) cnt_d = cnt_inc;
				else if (b == "e" || b == "E") begin
					mode_d = M_EXPSTART; cnt_d = cnt_inc;
				end else begin
					t0 = '{1'b1, 1'b0, K_FLOAT, 8'h00}; restart = 1'b1;
				end
			end
			M_EXPSTART: begin
				if (is_digit(b) || b == "+" || b == "-") begin
					mode_d = M_EXPDIG; cnt_d = cnt_inc;
				end else begin
					t0 = '{1'b1, 1'b0, K_FLOAT, 8'h00}; restart = 1'b1;
				end
			end
			M_EXPDIG: begin
				if (is_digit(b)) cnt_d = cnt_inc;
				else begin
					t0 = '{1'b1, 1'b0, K_FLOAT, 8'h00}; restart = 1'b1;
				end
			end
			M_STRING: begin
				if (esc_q) begin
					if (b == 8'h00) begin
						t0 = '{1'b1, 1'b1, K_ERR, 8'h00}; halt_d = 1'b1; mode_d = M_IDLE;
					end else begin
						esc_d = 1'b0; cnt_d = cnt_inc;
					end
				end else if (b == quote_q) begin
					cnt_d = cnt_inc; len0 = cnt_inc; mode_d = M_IDLE;
					t0 = '{1'b1, 1'b0, K_STR, 8'h00};
				end else if (b == 8'h0a || b == 8'h0d || b == 8'h00) begin
					t0 = '{1'b1, 1'b1, K_ERR, 8'h00}; halt_d = 1'b1; mode_d = M_IDLE;
				end else begin
					if (b == "\\") esc_d = 1'b1;
					cnt_d = cnt_inc;
				end
			end
			M_OPER: begin
				if (pcnt2_q) begin
					k = op3(pre0_q, pre1_q, b);
					if (k != K_NONE) begin
						len0 = LENGTH_BITS'(3); mode_d = M_IDLE;
						t0 = '{1'b1, 1'b0, k, 8'h00};
					end else begin
						len0 = LENGTH_BITS'(2); restart = 1'b1;
						t0 = '{1'b1, 1'b0, op2(pre0_q, pre1_q), 8'h00};
					end
				end else begin
					k = op2(pre0_q, b);
					if (k != K_NONE && is_prefix3(pre0_q, b)) begin
						pre1_d = b; pcnt2_d = 1'b1; cnt_d = LENGTH_BITS'(2);
					end else if (k != K_NONE) begin
						len0 = LENGTH_BITS'(2); mode_d = M_IDLE;
						t0 = '{1'b1, 1'b0, k, 8'h00};
					end else begin
						len0 = LENGTH_BITS'(1); restart = 1'b1;
						t0 = '{1'b1, 1'b0, K_CHAR, pre0_q};
					end
				end
			end
			default: restart = 1'b1;
		endcase

		// Token start.
		if (restart) begin
			mode_d = M_IDLE;
			if (b == 8'h00) t1 = '{1'b1, 1'b1, K_EOF, 8'h00};
			else if (!is_space(b)) begin
				tline_d = line_q; tcol_d = col_q; cnt_d = LENGTH_BITS'(1);
				if (b == "/") mode_d = M_SLASH;
				else if (is_alpha(b)) begin
					mode_d = M_IDENT; word_d = word_t'(b); long_d = 1'b0;
				end else if (is_digit(b)) mode_d = (b == "0") ? M_ZERO : M_INT;
				else if (b == "\"" || b == "'") begin
					mode_d = M_STRING; quote_d = b; esc_d = 1'b0;
				end else if (is_opstart(b)) begin
					mode_d = M_OPER; pre0_d = b; pcnt2_d = 1'b0;
				end else t1 = '{1'b1, 1'b1, K_CHAR, b};
			end
		end
		// Truncated operator tokens keep their length for the emitted token.
		if (m == M_OPER && t0.valid) cnt_d = restart ? cnt_d : len0;

		// A halted block produces no results.
		if (halt_q) begin
			t0.valid = 1'b0; t1.valid = 1'b0;
		end
	end

	assign tok_line = tline_q;
	assign tok_col  = tcol_q;
	assign tok_len  = len0;
	assign cur_line = line_q;
	assign cur_col  = col_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; long_q <= 1'b0; pcnt2_q <= 1'b0; quote_q <= '0;
			esc_q <= 1'b0; star_q <= 1'b0; halt_q <= 1'b0;
			line_q <= LINE_BITS'(1); col_q <= COLUMN_BITS'(1);
			tline_q <= LINE_BITS'(1); tcol_q <= COLUMN_BITS'(1); cnt_q <= '0;
		end else if (step && !halt_q) begin
			mode_q <= mode_d; long_q <= long_d; pcnt2_q <= pcnt2_d; quote_q <= quote_d;
			esc_q <= esc_d; star_q <= star_d; halt_q <= halt_d;
			tline_q <= tline_d; tcol_q <= tcol_d; cnt_q <= cnt_d;
			if (b == 8'h0a) begin
				line_q <= (line_q == LMAX) ? line_q : line_q + 1'b1;
				col_q <= COLUMN_BITS'(1);
			end else col_q <= (col_q == CMAX) ? col_q : col_q + 1'b1;
		end
	end

	// Word and operator buffers.
	always_ff @(posedge clk) begin
		if (step && !halt_q) begin
			word_q <= word_d; pre0_q <= pre0_d; pre1_q <= pre1_d;
		end
	end

endmodule

[rtl/stl_outq.sv]
module stl_outq
	import stl_pkg::*;
#(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push0,
	input  logic         push1,
	input  logic [W-1:0] d0,
	input  logic [W-1:0] d1,
	input  logic         pop,
	output logic         empty,
	output logic         room,
	output logic [W-1:0] head
);

	// Four-entry queue: room means at least two free entries.
	logic [W-1:0] mem_q [4];
	logic [1:0]   wp_q, rp_q;
	logic [2:0]   cnt_q;
	logic [1:0]   n_in;

	assign n_in  = 2'(push0) + 2'(push1);
	assign empty = (cnt_q == 3'd0);
	assign room  = (cnt_q <= 3'd2);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + n_in;
			rp_q <= rp_q + 2'(pop);
			cnt_q <= cnt_q + 3'(n_in) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) mem_q[wp_q] <= d0;
		if (push1) mem_q[push0 ? wp_q + 2'd1 : wp_q] <= d1;
	end

endmodule

[rtl/script_token_lexer.sv]
// Channel  | Signals                                   | Direction
// input    | in_valid, in_stall, text_byte             | into the block
// result   | out_valid, out_stall, token fields        | out of the block
// config   | cfg_we, cfg_wdata (drop_comments)         | into the block
// A byte is decoded in the cycle of its transfer; its results, up to two, enter a
// four-entry result queue and leave one per cycle from the queue head while out_stall is low.
// A new byte can be accepted every cycle; in_stall rises when the
// queue has fewer than two free entries. Reset clears all control state and the queue.
module script_token_lexer
	import stl_pkg::*;
#(
	parameter int LINE_BITS   = LINE_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             text_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [5:0]             token_kind,
	output logic [7:0]             op_char,
	output logic [LINE_BITS-1:0]   start_line,
	output logic [COLUMN_BITS-1:0] start_column,
	output logic [LENGTH_BITS-1:0] token_length,
	output logic                   last_of_run
);

	localparam int W = 6 + 8 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1;

	logic                   drop_q, step, empty, room;
	tok_t                   t0, t1;
	logic [LINE_BITS-1:0]   tl, cl;
	logic [COLUMN_BITS-1:0] tc, cc;
	logic [LENGTH_BITS-1:0] tn;
	logic [W-1:0]           d0, d1, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) drop_q <= 1'b1;
		else if (cfg_we) drop_q <= cfg_wdata;
	end

	assign in_stall = !room;
	assign step     = in_valid && room;

	stl_core #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS),
		.LENGTH_BITS(LENGTH_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .b(text_byte), .drop(drop_q),
		.t0(t0), .t1(t1), .tok_line(tl), .tok_col(tc), .tok_len(tn),
		.cur_line(cl), .cur_col(cc)
	);

	// Pack the results; the first slot is last only when the second is absent.
	always_comb begin
		d0 = {t0.kind, t0.ch, t0.use_cur ? cl : tl, t0.use_cur ? cc : tc,
			t0.kind == K_ERR ? LENGTH_BITS'(0) : tn, !t1.valid};
		d1 = {t1.kind, t1.ch, t1.use_cur ? cl : tl, t1.use_cur ? cc : tc,
			t1.kind == K_CHAR ? LENGTH_BITS'(1) : LENGTH_BITS'(0), 1'b1};
	end

	stl_outq #(.W(W)) u_outq (
		.clk(clk), .arst_n(arst_n), .push0(step && t0.valid), .push1(step && t1.valid),
		.d0(d0), .d1(d1), .pop(!empty && !out_stall), .empty(empty), .room(room),
		.head(head)
	);

	assign out_valid = !empty;
	assign {token_kind, op_char, start_line, start_column, token_length, last_of_run} = head;

endmodule

[dv/tb_script_token_lexer.sv]
`timescale 1ns / 100ps

module tb_script_token_lexer;

	localparam int LINE_MAX   = (1 << 20) - 1;
	localparam int COLUMN_MAX = (1 << 16) - 1;
	localparam int LENGTH_MAX = (1 << 16) - 1;

	typedef struct {
		int kind;
		int ch;
		int line;
		int col;
		int len;
		bit last;
	} lex_token_t;

	typedef struct {
		string text;
		bit    nul;
		bit    drop;
		int    want_kind;
	} lex_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  token_kind;
	logic [7:0]  op_char;
	logic [19:0] start_line;
	logic [15:0] start_column;
	logic [15:0] token_length;
	logic        last_of_run;

	script_token_lexer DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte),
		.out_valid(out_valid), .out_stall(out_stall), .token_kind(token_kind),
		.op_char(op_char), .start_line(start_line), .start_column(start_column),
		.token_length(token_length), .last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	initial begin
		#5000000;
		$display("tb_script_token_lexer NOT OK");
		$finish;
	end

	// Shadow copy of the lexer state.
	string      op_names [20] = '{"==", "===", "!=", "!==", "<=", "<<", "<<=", ">=", ">>",
		">>>", ">>=", "+=", "-=", "++", "--", "&=", "&&", "|=", "||", "^="};
	string      kw_names [15] = '{"if", "else", "do", "while", "for", "break", "continue",
		"function", "return", "var", "true", "false", "null", "undefined", "new"};
	bit         drop_cmt = 1'b1;
	logic [3:0] mode = stl_pkg::M_IDLE;
	string      word = "";
	bit         word_long = 1'b0;
	byte unsigned pre0 = 0, pre1 = 0;
	int         pre_count = 0;
	byte unsigned quote = 0;
	bit         esc = 1'b0, star = 1'b0, halted = 1'b0;
	int         cur_line = 1, cur_col = 1, tok_line = 1, tok_col = 1, tok_len = 0;
	int         last_pred_kind = -1;

	lex_token_t byte_tokens [$];
	lex_token_t expected_tokens [$];
	int         errors = 0;
	int         tokens_checked = 0;
	int         bytes_sent = 0;

	function automatic int sat(input int v, input int maxv);
		return (v >= maxv) ? maxv : v + 1;
	endfunction

	function automatic bit alpha_c(input byte unsigned b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == "$";
	endfunction

	function automatic bit digit_c(input byte unsigned b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic int op_lookup(input string s);
		for (int i = 0; i < 20; i++)
			if (op_names[i] == s) return 6 + i;
		return 0;
	endfunction

	function automatic bit op_may_grow(input string s);
		for (int i = 0; i < 20; i++)
			if (op_names[i].len() == 3 && op_names[i].substr(0, 1) == s) return 1'b1;
		return 1'b0;
	endfunction

	function automatic int word_token_kind();
		if (!word_long)
			for (int i = 0; i < 15; i++)
				if (kw_names[i] == word) return int'(stl_pkg::K_KW0) + i;
		return int'(stl_pkg::K_ID);
	endfunction

	function automatic void emit(input int kind, input int ch, input int line, input int col,
		input int len);
		lex_token_t t;
		t.kind = kind;
		t.ch = ch;
		t.line = line;
		t.col = col;
		t.len = len;
		t.last = 1'b0;
		byte_tokens.insert(byte_tokens.size(), t);
	endfunction

	function automatic void emit_current(input int kind, input int ch);
		emit(kind, ch, tok_line, tok_col, tok_len);
	endfunction

	function automatic void raise_error(input int line, input int col);
		emit(int'(stl_pkg::K_ERR), 0, line, col, 0);
		halted = 1'b1;
		mode = stl_pkg::M_IDLE;
	endfunction

	function automatic void begin_token(input byte unsigned b);
		mode = stl_pkg::M_IDLE;
		if (b == 0) begin
			emit(int'(stl_pkg::K_EOF), 0, cur_line, cur_col, 0);
			return;
		end
		if (b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d) return;
		tok_line = cur_line;
		tok_col = cur_col;
		tok_len = 1;
		if (b == "/") begin
			mode = stl_pkg::M_SLASH;
		end else if (alpha_c(b)) begin
			mode = stl_pkg::M_IDENT;
			word = $sformatf("%c", b);
			word_long = 1'b0;
		end else if (digit_c(b)) begin
			mode = (b == "0") ? stl_pkg::M_ZERO : stl_pkg::M_INT;
		end else if (b == "\"" || b == "'") begin
			mode = stl_pkg::M_STRING;
			quote = b;
			esc = 1'b0;
		end else if (op_lookup($sformatf("%c=", b)) != 0 || b == "!" || b == "<" || b == ">") begin
			mode = stl_pkg::M_OPER;
			pre0 = b;
			pre_count = 1;
		end else begin
			emit_current(int'(stl_pkg::K_CHAR), b);
		end
	endfunction

	// Returns 1 when the byte still has to open a new token.
	function automatic bit continue_token(input byte unsigned b);
		int k;
		case (mode)
			stl_pkg::M_SLASH: begin
				if (b == "/" || b == "*") begin
					mode = (b == "/") ? stl_pkg::M_LINECMT : stl_pkg::M_BLOCKCMT;
					star = 1'b0;
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				emit_current(int'(stl_pkg::K_CHAR), "/");
				return 1'b1;
			end
			stl_pkg::M_LINECMT: begin
				if (b == 0 || b == 8'h0a) begin
					if (!drop_cmt) emit_current(int'(stl_pkg::K_CMT), 0);
					return 1'b1;
				end
				tok_len = sat(tok_len, LENGTH_MAX);
				return 1'b0;
			end
			stl_pkg::M_BLOCKCMT: begin
				if (b == 0) begin
					raise_error(tok_line, tok_col);
					return 1'b0;
				end
				tok_len = sat(tok_len, LENGTH_MAX);
				if (star && b == "/") begin
					if (!drop_cmt) emit_current(int'(stl_pkg::K_CMT), 0);
					mode = stl_pkg::M_IDLE;
					return 1'b0;
				end
				star = (b == "*");
				return 1'b0;
			end
			stl_pkg::M_IDENT: begin
				if (alpha_c(b) || digit_c(b)) begin
					if (!word_long && tok_len < 9) word = {word, $sformatf("%c", b)};
					else word_long = 1'b1;
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				emit_current(word_token_kind(), 0);
				return 1'b1;
			end
			stl_pkg::M_ZERO: begin
				if (b == "x" || b == "X") begin
					mode = stl_pkg::M_HEX;
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				mode = stl_pkg::M_INT;
				return continue_token(b);
			end
			stl_pkg::M_INT, stl_pkg::M_FRAC: begin
				if (digit_c(b)) begin
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				if (b == "." && mode == stl_pkg::M_INT) begin
					mode = stl_pkg::M_FRAC;
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				if (b == "e" || b == "E") begin
					mode = stl_pkg::M_EXPSTART;
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				emit_current((mode == stl_pkg::M_INT) ? int'(stl_pkg::K_INT)
					: int'(stl_pkg::K_FLOAT), 0);
				return 1'b1;
			end
			stl_pkg::M_HEX: begin
				if (digit_c(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				emit_current(int'(stl_pkg::K_INT), 0);
				return 1'b1;
			end
			stl_pkg::M_EXPSTART, stl_pkg::M_EXPDIG: begin
				if (digit_c(b) || (mode == stl_pkg::M_EXPSTART && (b == "+" || b == "-"))) begin
					mode = stl_pkg::M_EXPDIG;
					tok_len = sat(tok_len, LENGTH_MAX);
					return 1'b0;
				end
				emit_current(int'(stl_pkg::K_FLOAT), 0);
				return 1'b1;
			end
			stl_pkg::M_STRING: begin
				if (esc) begin
					if (b == 0) begin
						raise_error(cur_line, cur_col);
						return 1'b0;
					end
					esc = 1'b0;
				end else if (b == quote) begin
					tok_len = sat(tok_len, LENGTH_MAX);
					emit_current(int'(stl_pkg::K_STR), 0);
					mode = stl_pkg::M_IDLE;
					return 1'b0;
				end else if (b == 8'h0a || b == 8'h0d || b == 0) begin
					raise_error(cur_line, cur_col);
					return 1'b0;
				end else if (b == "\\") begin
					esc = 1'b1;
				end
				tok_len = sat(tok_len, LENGTH_MAX);
				return 1'b0;
			end
			stl_pkg::M_OPER: begin
				if (pre_count >= 2) begin
					// A zero byte never completes a three-character operator.
					k = (b != 0) ? op_lookup($sformatf("%c%c%c", pre0, pre1, b)) : 0;
					if (k != 0) begin
						tok_len = 3;
						emit_current(k, 0);
						mode = stl_pkg::M_IDLE;
						return 1'b0;
					end
					tok_len = 2;
					emit_current(op_lookup($sformatf("%c%c", pre0, pre1)), 0);
					return 1'b1;
				end
				k = op_lookup($sformatf("%c%c", pre0, b));
				tok_len = (k != 0) ? 2 : 1;
				if (k != 0 && op_may_grow($sformatf("%c%c", pre0, b))) begin
					pre1 = b;
					pre_count = 2;
					return 1'b0;
				end
				if (k != 0) begin
					emit_current(k, 0);
					mode = stl_pkg::M_IDLE;
					return 1'b0;
				end
				emit_current(int'(stl_pkg::K_CHAR), pre0);
				return 1'b1;
			end
			default: return 1'b1;
		endcase
	endfunction

	// Works out the tokens that one transferred byte produces.
	function automatic void predict_tokens(input byte unsigned b);
		if (halted) return;
		byte_tokens.delete();
		if (continue_token(b) && !halted) begin_token(b);
		if (b == 8'h0a) begin
			cur_line = sat(cur_line, LINE_MAX);
			cur_col = 1;
		end else begin
			cur_col = sat(cur_col, COLUMN_MAX);
		end
		if (byte_tokens.size() > 0) begin
			byte_tokens[byte_tokens.size() - 1].last = 1'b1;
			last_pred_kind = byte_tokens[byte_tokens.size() - 1].kind;
		end
		foreach (byte_tokens[i]) expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
	endfunction

	// True when the byte would end the run with an error token.
	function automatic bit breaks_text(input byte unsigned b);
		if (mode == stl_pkg::M_STRING)
			return b == 0 || (!esc && (b == 8'h0a || b == 8'h0d));
		return mode == stl_pkg::M_BLOCKCMT && b == 0;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic byte unsigned pick_char(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// Each transfer is predicted at the edge that accepts it.
	task automatic send_byte(input byte unsigned b, input bit gaps);
		int g;
		in_valid <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_tokens(b);
		bytes_sent++;
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic feed(input byte unsigned b, input bit gaps);
		if (breaks_text(b)) b = "a";
		send_byte(b, gaps);
	endtask

	task automatic feed_text(input string s, input bit gaps);
		for (int i = 0; i < s.len(); i++) feed(s[i], gaps);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_tokens.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_drop(input bit v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		drop_cmt = v;
	endtask

	// One random piece of script text, mostly well formed.
	task automatic send_snippet(input bit gaps);
		int n;
		case ($urandom_range(0, 9))
			0: begin
				feed(pick_char("abcxyzQ_$"), gaps);
				n = $urandom_range(0, 12);
				repeat (n) feed(pick_char("abefinortuwxZ_$09"), gaps);
			end
			1: feed_text(kw_names[$urandom_range(0, 14)], gaps);
			2: begin
				if ($urandom_range(0, 3) == 0) begin
					feed_text($urandom_range(0, 1) ? "0x" : "0X", gaps);
					n = $urandom_range(0, 5);
					repeat (n) feed(pick_char("0123456789abcdefABCDEF"), gaps);
				end else begin
					n = $urandom_range(1, 4);
					repeat (n) feed(pick_char("0123456789"), gaps);
					if ($urandom_range(0, 1)) begin
						feed(".", gaps);
						n = $urandom_range(0, 3);
						repeat (n) feed(pick_char("0123456789"), gaps);
					end
					if ($urandom_range(0, 2) == 0) begin
						feed(pick_char("eE"), gaps);
						if ($urandom_range(0, 1)) feed(pick_char("+-"), gaps);
						n = $urandom_range(0, 3);
						repeat (n) feed(pick_char("0123456789"), gaps);
					end
				end
			end
			3: begin
				feed(pick_char("'\""), gaps);
				n = $urandom_range(0, 8);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) feed("\\", gaps);
					feed($urandom_range(1, 255), gaps);
				end
				feed(pick_char("'\""), gaps);
			end
			4: begin
				feed_text("//", gaps);
				n = $urandom_range(0, 10);
				repeat (n) feed($urandom_range(1, 255), gaps);
				feed(8'h0a, gaps);
			end
			5: begin
				feed_text("/*", gaps);
				n = $urandom_range(0, 10);
				repeat (n) feed($urandom_range(0, 2) ? $urandom_range(1, 255) : "*", gaps);
				feed_text("*/", gaps);
			end
			6: feed_text(op_names[$urandom_range(0, 19)], gaps);
			7: feed(pick_char("()[]{};,.?:~*%/=!<>+-&|^@#"), gaps);
			8: begin
				n = $urandom_range(1, 4);
				repeat (n) feed($urandom_range(0, 255), gaps);
			end
			default: feed(pick_char({" \t\n\r", 8'h00}), gaps);
		endcase
		if ($urandom_range(0, 1)) feed(" ", gaps);
	endtask

	// Result side: random stall bursts, short mostly.
	int stall_hold = 0;
	always @(posedge clk) begin
		int r;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 6);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end
		end
	end

	// Each transfer on the result side is compared with the oldest expected token.
	always @(posedge clk) begin
		lex_token_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("token with no expectation: kind %0d", token_kind);
				errors++;
			end else begin
				e = expected_tokens.pop_front();
				tokens_checked++;
				if (token_kind != e.kind) begin
					$error("token_kind expected %0d got %0d", e.kind, token_kind);
					errors++;
				end
				if (op_char != e.ch) begin
					$error("op_char expected %0d got %0d", e.ch, op_char);
					errors++;
				end
				if (start_line != e.line) begin
					$error("start_line expected %0d got %0d", e.line, start_line);
					errors++;
				end
				if (start_column != e.col) begin
					$error("start_column expected %0d got %0d", e.col, start_column);
					errors++;
				end
				if (token_length != e.len) begin
					$error("token_length expected %0d got %0d", e.len, token_length);
					errors++;
				end
				if (last_of_run != e.last) begin
					$error("last_of_run expected %0d got %0d", e.last, last_of_run);
					errors++;
				end
			end
		end
	end

	lex_row_t rows [] = '{
		'{"if ", 0, 1, 26}, '{"undefined ", 0, 1, 39}, '{"undefineds ", 0, 1, 1},
		'{"abcdefghijkl ", 0, 1, 1}, '{"_$Z9 ", 0, 1, 1}, '{"0 ", 0, 1, 2},
		'{"0x1fA ", 0, 1, 2}, '{"0X ", 0, 1, 2}, '{"123 ", 0, 1, 2},
		'{"1.5e+3 ", 0, 1, 3}, '{"7e ", 0, 1, 3}, '{"2. ", 0, 1, 3},
		'{"'a\\'b\" ", 0, 1, -1}, '{"' \"\\\nq\" ", 0, 1, 4}, '{"/ ", 0, 1, 41},
		'{"// note\n", 0, 0, 5}, '{"/* ** */ ", 0, 0, 5}, '{"=== ", 0, 0, 7},
		'{"!== ", 0, 1, 9}, '{">>>= ", 0, 1, 41}, '{"<<= ", 0, 1, 12},
		'{"a+=b ", 0, 1, 1}, '{"++--&&||^= ", 0, 1, 25}, '{"@ ", 0, 1, 41},
		'{"x", 1, 1, 0}
	};

	initial begin
		int target;
		int pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, each ending on a known token where one is given.
		foreach (rows[i]) begin
			if (rows[i].drop != drop_cmt) write_drop(rows[i].drop);
			last_pred_kind = -1;
			feed_text(rows[i].text, 1'b1);
			if (rows[i].nul) feed(8'h00, 1'b1);
			if (rows[i].want_kind >= 0 && last_pred_kind != rows[i].want_kind) begin
				$error("row %0d: token_kind expected %0d got %0d", i, rows[i].want_kind,
					last_pred_kind);
				errors++;
			end
		end

		// Random text in three phases with the comment setting changed between them.
		for (int p = 0; p < 3; p++) begin
			write_drop(p != 1);
			target = bytes_sent + 400;
			while (bytes_sent < target) send_snippet($urandom_range(0, 9) != 0);
		end

		// The run ends on one of the three error cases, which halts the block.
		wait_drained();
		pick = $urandom_range(0, 2);
		feed_text((pick == 0) ? "/* open " : "'ab", 1'b1);
		if (pick == 2) feed("\\", 1'b1);
		send_byte((pick == 1) ? 8'h0a : 8'h00, 1'b1);
		repeat (6) send_byte($urandom_range(0, 255), 1'b1);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d text bytes, checked %0d tokens across both comment settings",
			bytes_sent, tokens_checked);
		$display("including keyword, number, string, operator, stall and error cases.");
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("tb_script_token_lexer OK");
		end else begin
			$display("tb_script_token_lexer NOT OK");
		end
		$finish;
	end

endmodule
